>>> hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  // default sizes
  localparam int DEQ_CAPACITY   = 16;
  localparam int DEQ_DATA_WIDTH = 32;

  // fixed port widths
  localparam int OP_WIDTH     = 3;
  localparam int VALUE_WIDTH  = 32;
  localparam int STATUS_WIDTH = 2;

  // operation codes
  localparam logic [OP_WIDTH-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_WIDTH-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_WIDTH-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_WIDTH-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_WIDTH-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_WIDTH-1:0] OP_PEEK_BACK  = 3'd5;

  // status codes
  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;     // run the accepted item this cycle
    logic respond;  // result registers are on the result ports
  } deq_cmd_t;

endpackage

>>> hw/rtl/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: accepts an item, then presents its result for one cycle.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  output deq_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic state_q;
  logic state_d;
  logic accept;

  // handshake
  assign busy_o = (state_q == ST_RESP);
  assign accept = start_i && !busy_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commands
  assign cmd_o.exec    = accept;
  assign cmd_o.respond = (state_q == ST_RESP);
  assign done_o        = cmd_o.respond;

endmodule

>>> hw/rtl/deq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_datapath
// Ring storage, front pointer, occupancy count and result registers.
// ----------------------------------------------------------------------------
module deq_datapath
  import deq_pkg::*;
#(
  parameter int CAPACITY   = DEQ_CAPACITY,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  deq_cmd_t                cmd_i,
  input  logic [OP_WIDTH-1:0]     op_i,
  input  logic [VALUE_WIDTH-1:0]  value_i,
  output logic [VALUE_WIDTH-1:0]  result_value_o,
  output logic [STATUS_WIDTH-1:0] status_o,
  output logic                    is_empty_o,
  output logic                    is_full_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  localparam logic [AW-1:0] LAST_POS = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
  localparam logic [SW-1:0] WRAP_SUM = SW'(CAPACITY);

  // pointer state
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;

  // result registers
  logic [STATUS_WIDTH-1:0] status_q, status_d;
  logic                    empty_q, full_q;
  logic                    hit_q;
  logic [DATA_WIDTH-1:0]   rdata_q;

  // ring memory
  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];

  logic                  is_push, is_read, is_front;
  logic                  cur_empty, cur_full;
  logic [AW-1:0]         front_dec, front_inc;
  logic [SW-1:0]         tail_sum, back_sum;
  logic [AW-1:0]         tail_pos, back_pos;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wr_word;
  logic [VALUE_WIDTH-1:0] rd_word;

  // word width adaption
  if (DATA_WIDTH >= VALUE_WIDTH) begin : g_wide
    assign wr_word = DATA_WIDTH'(value_i);
    assign rd_word = rdata_q[VALUE_WIDTH-1:0];
  end else begin : g_narrow
    assign wr_word = value_i[DATA_WIDTH-1:0];
    assign rd_word = VALUE_WIDTH'(rdata_q);
  end

  // op decode and occupancy flags
  assign is_push   = (op_i == OP_PUSH_FRONT) || (op_i == OP_PUSH_BACK);
  assign is_read   = (op_i == OP_POP_FRONT) || (op_i == OP_POP_BACK) ||
                     (op_i == OP_PEEK_FRONT) || (op_i == OP_PEEK_BACK);
  assign is_front  = (op_i == OP_POP_FRONT) || (op_i == OP_PEEK_FRONT);
  assign cur_empty = (count_q == '0);
  assign cur_full  = (count_q == FULL_CNT);

  // ring positions with wrap at capacity
  assign front_dec = (front_q == '0) ? LAST_POS : front_q - AW'(1);
  assign front_inc = (front_q == LAST_POS) ? '0 : front_q + AW'(1);
  assign tail_sum  = SW'(front_q) + SW'(count_q);
  assign back_sum  = tail_sum - SW'(1);
  assign tail_pos  = (tail_sum >= WRAP_SUM) ? AW'(tail_sum - WRAP_SUM) : AW'(tail_sum);
  assign back_pos  = (back_sum >= WRAP_SUM) ? AW'(back_sum - WRAP_SUM) : AW'(back_sum);

  // memory access
  assign we    = cmd_i.exec && is_push && !cur_full;
  assign re    = cmd_i.exec && is_read && !cur_empty;
  assign waddr = (op_i == OP_PUSH_FRONT) ? front_dec : tail_pos;
  assign raddr = is_front ? front_q : back_pos;

  // pointer update and status
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = ST_OK;
    if (is_push && cur_full) begin
      status_d = ST_FULL;
    end else if (is_read && cur_empty) begin
      status_d = ST_EMPTY;
    end
    if (we) begin
      count_d = count_q + CW'(1);
      if (op_i == OP_PUSH_FRONT) begin
        front_d = front_dec;
      end
    end
    if (re) begin
      if (op_i == OP_POP_FRONT) begin
        front_d = front_inc;
        count_d = count_q - CW'(1);
      end else if (op_i == OP_POP_BACK) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  // pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      empty_q  <= (count_d == '0);
      full_q   <= (count_d == FULL_CNT);
      hit_q    <= re;
    end
  end

  // ring memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wr_word;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // result ports
  assign result_value_o = hit_q ? rd_word : '0;
  assign status_o       = status_q;
  assign is_empty_o     = empty_q;
  assign is_full_o      = full_q;

endmodule

>>> hw/rtl/double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue on a ring memory with push, pop and peek at
// both ends.
// Latency: the result strobe done_o rises in the cycle after an item is
// accepted; the receiver cannot stall it.
// Throughput: the block takes no new item until it is through with the last;
// busy_o is high during the result cycle and holds off start_i.
// Reset: front pointer and occupancy clear at once (deque empty); the ring
// memory is not cleared, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int CAPACITY   = DEQ_CAPACITY,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [OP_WIDTH-1:0]     op_i,
  input  logic [VALUE_WIDTH-1:0]  value_i,
  output logic                    done_o,
  output logic [VALUE_WIDTH-1:0]  result_value_o,
  output logic [STATUS_WIDTH-1:0] status_o,
  output logic                    is_empty_o,
  output logic                    is_full_o
);

  deq_cmd_t cmd;

  // sequencer
  deq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // storage and pointers
  deq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .value_i        (value_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

  // every accepted item gets its result in the next cycle
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted item without result strobe");

  // the result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // errors carry a zero word
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (result_value_o == '0))
    else $error("error result with nonzero word");

  // a rejected push leaves the deque full, an empty read leaves it empty
  a_err_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((status_o == ST_FULL) || (status_o == ST_EMPTY))) |->
      ((status_o == ST_FULL) ? is_full_o : is_empty_o))
    else $error("error status disagrees with occupancy flags");

endmodule

>>> tb/deque_tracker_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_tracker_pkg
// Shadow model of the bounded double-ended queue. It keeps its own ring,
// front pointer and occupancy, predicts the answer to every accepted item
// and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
package deque_tracker_pkg;
  import deq_pkg::*;

  // one predicted answer
  typedef struct {
    logic [VALUE_WIDTH-1:0]  value;
    logic [STATUS_WIDTH-1:0] status;
    logic                    empty;
    logic                    full;
  } deque_answer_t;

  class deque_tracker;
    localparam int DEPTH = DEQ_CAPACITY;

    logic [VALUE_WIDTH-1:0] ring [DEPTH];
    logic [3:0]             front_ptr;
    logic [4:0]             fill_count;
    deque_answer_t          pending_answers [$];
    int                     mismatches;

    function new();
      front_ptr  = '0;
      fill_count = '0;
      mismatches = 0;
    endfunction

    // predict the answer to an accepted item and update the shadow state
    function void note_request(logic [OP_WIDTH-1:0] op, logic [VALUE_WIDTH-1:0] value);
      deque_answer_t ans;
      logic [3:0]    slot;
      ans.value  = '0;
      ans.status = ST_OK;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill_count == DEPTH) begin
            ans.status = ST_FULL;
          end else begin
            if (op == OP_PUSH_FRONT) begin
              front_ptr = front_ptr - 4'd1;
              slot      = front_ptr;
            end else begin
              slot = front_ptr + fill_count[3:0];
            end
            ring[slot] = value;
            fill_count = fill_count + 5'd1;
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
          if (fill_count == 0) begin
            ans.status = ST_EMPTY;
          end else begin
            if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) slot = front_ptr;
            else slot = front_ptr + fill_count[3:0] - 4'd1;
            ans.value = ring[slot];
            if (op == OP_POP_FRONT) begin
              front_ptr  = front_ptr + 4'd1;
              fill_count = fill_count - 5'd1;
            end else if (op == OP_POP_BACK) begin
              fill_count = fill_count - 5'd1;
            end
          end
        end
        default: ;  // spare op codes leave the state alone
      endcase
      ans.empty = (fill_count == 0);
      ans.full  = (fill_count == DEPTH);
      pending_answers.push_back(ans);
    endfunction

    // compare a strobed result with the oldest prediction
    function void check_response(logic [VALUE_WIDTH-1:0] value, logic [STATUS_WIDTH-1:0] status,
                                 logic empty, logic full);
      deque_answer_t ans;
      if (pending_answers.size() == 0) begin
        $error("result strobe with no item outstanding");
        mismatches++;
        return;
      end
      ans = pending_answers.pop_front();
      if (value !== ans.value) begin
        $error("result_value: expected %h, got %h", ans.value, value);
        mismatches++;
      end
      if (status !== ans.status) begin
        $error("status: expected %0d, got %0d", ans.status, status);
        mismatches++;
      end
      if (empty !== ans.empty) begin
        $error("is_empty: expected %b, got %b", ans.empty, empty);
        mismatches++;
      end
      if (full !== ans.full) begin
        $error("is_full: expected %b, got %b", ans.full, full);
        mismatches++;
      end
    endfunction
  endclass

endpackage

>>> tb/tb_double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top
// Self-checking bench for the bounded double-ended queue. A directed pass
// walks the empty and full corners, spare op codes and data extremes, then
// random bursts lean toward pushes or pops so the queue swings between
// empty and full. Every strobed result is checked against a shadow model.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;
  import deq_pkg::*;
  import deque_tracker_pkg::*;

  localparam logic [OP_WIDTH-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_WIDTH-1:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 500;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [OP_WIDTH-1:0]     op_i;
  logic [VALUE_WIDTH-1:0]  value_i;
  logic                    done_o;
  logic [VALUE_WIDTH-1:0]  result_value_o;
  logic [STATUS_WIDTH-1:0] status_o;
  logic                    is_empty_o;
  logic                    is_full_o;

  deque_tracker tracker = new();

  double_ended_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // watch accepted items and strobed results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) tracker.note_request(op_i, value_i);
      if (done_o) tracker.check_response(result_value_o, status_o, is_empty_o, is_full_o);
    end
  end

  // send one item after an idle gap, return at the edge that accepts it
  task automatic issue_request(logic [OP_WIDTH-1:0] op, logic [VALUE_WIDTH-1:0] value,
                               int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_i    <= op;
    value_i <= value;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  // data word with extra weight on the extremes
  function automatic logic [VALUE_WIDTH-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // op code drawn with a given push percentage
  function automatic logic [OP_WIDTH-1:0] pick_op(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    if (r < 3 + push_pct) return ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    case ($urandom_range(0, 5))
      0, 1:    return OP_POP_FRONT;
      2, 3:    return OP_POP_BACK;
      4:       return OP_PEEK_FRONT;
      default: return OP_PEEK_BACK;
    endcase
  endfunction

  // stimulus
  initial begin
    int sent;
    int burst_len;
    int push_pct;
    bit no_idle;
    int wait_cycles;

    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    op_i    <= OP_PUSH_FRONT;
    value_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reads and spare codes on the empty deque
    issue_request(OP_POP_FRONT, pick_word(), $urandom_range(0, 8));
    issue_request(OP_POP_BACK, pick_word(), $urandom_range(0, 8));
    issue_request(OP_PEEK_FRONT, pick_word(), $urandom_range(0, 8));
    issue_request(OP_PEEK_BACK, pick_word(), $urandom_range(0, 8));
    issue_request(OP_SPARE_LO, '1, $urandom_range(0, 8));
    issue_request(OP_SPARE_HI, '0, $urandom_range(0, 8));
    // data extremes at both ends
    issue_request(OP_PUSH_FRONT, '0, $urandom_range(0, 8));
    issue_request(OP_PUSH_BACK, '1, $urandom_range(0, 8));
    issue_request(OP_PEEK_FRONT, '0, $urandom_range(0, 8));
    issue_request(OP_PEEK_BACK, '0, $urandom_range(0, 8));
    // fill up, then push into the full deque from both ends
    for (int i = 0; i < DEQ_CAPACITY - 2; i++) begin
      issue_request(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom(), $urandom_range(0, 2));
    end
    issue_request(OP_PUSH_FRONT, $urandom(), $urandom_range(0, 8));
    issue_request(OP_PUSH_BACK, $urandom(), $urandom_range(0, 8));

    // random bursts leaning toward filling, draining or neither
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 75;
        1:       push_pct = 20;
        default: push_pct = 45;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst_len && sent < RANDOM_ITEMS; i++) begin
        issue_request(pick_op(push_pct), pick_word(), no_idle ? 0 : $urandom_range(0, 8));
        sent++;
      end
    end
    start_i <= 1'b0;

    // drain outstanding results, then let the bench idle before the verdict
    wait_cycles = 0;
    while (tracker.pending_answers.size() != 0 && wait_cycles < 100) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (4) @(posedge clk_i);

    if (tracker.pending_answers.size() != 0) begin
      $error("%0d results never arrived", tracker.pending_answers.size());
    end
    if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
